FILE: hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int PRIO_W   = 16;
  localparam int OCC_W    = 5;
  localparam int STAT_W   = 2;

  localparam logic       OP_ENQ   = 1'b0;
  localparam logic       OP_DEQ   = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // broadcast to every cell in the cycle a transfer commits
  typedef struct packed {
    logic   enq;     // insert new_entry in sorted position
    logic   deq;     // shift everything one cell toward the head
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count and result register.
//
// Bounded priority queue of CAPACITY (value, priority) pairs held in a row
// of cells, sorted so that cell 0 holds the entry served next (largest
// signed priority; ties leave in arrival order). Each input transfer is an
// enqueue (in_tuser = 0) or a dequeue (in_tuser = 1) and yields exactly one
// result transfer with the removed value, a status (0 done, 1 dequeue on
// empty, 2 enqueue dropped because full) and the occupancy after the item.
// Every cell compares the incoming priority with its own in parallel and,
// in the same cycle, either keeps its entry, takes the new one or takes its
// neighbor's, so one item per cycle is sustained; the result lands in a
// single output register in the cycle after the input transfer. The input
// is stalled only while that register holds a result that is not being
// taken. No clearing pass is needed after reset.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] item_value, [47:32] item_priority
  input  logic [0:0]  in_tuser,   // [0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] out_value, [36:32] occupancy, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic in_xfer;
  logic is_full;
  logic is_empty;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OCC_W-1:0]  out_occ_r;
  logic [VAL_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;

  cell_ctrl_t ctrl;
  entry_t     cell_entry [CAPACITY];
  logic       cell_keep  [CAPACITY];
  logic       occupied   [CAPACITY];

  // output register frees up in the same cycle it is drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign ctrl.enq = in_xfer && (in_tuser[0] == OP_ENQ) && !is_full;
  assign ctrl.deq = in_xfer && (in_tuser[0] == OP_DEQ) && !is_empty;
  assign ctrl.new_entry.value = $signed(in_tdata[31:0]);
  assign ctrl.new_entry.prio  = $signed(in_tdata[47:32]);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occupied[gi] = (CNT_W'(gi) < count_r);
      if (gi == 0) begin : g_head
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occupied[gi]),
          .left_keep   (1'b1),
          .left_entry  (ctrl.new_entry),
          .right_entry (cell_entry[gi+1]),
          .keep        (cell_keep[gi]),
          .entry       (cell_entry[gi])
        );
      end else if (gi == CAPACITY - 1) begin : g_tail
        // tail refills from itself on dequeue; that slot drops out of the count
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occupied[gi]),
          .left_keep   (cell_keep[gi-1]),
          .left_entry  (cell_entry[gi-1]),
          .right_entry (cell_entry[gi]),
          .keep        (cell_keep[gi]),
          .entry       (cell_entry[gi])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .ctrl        (ctrl),
          .occupied    (occupied[gi]),
          .left_keep   (cell_keep[gi-1]),
          .left_entry  (cell_entry[gi-1]),
          .right_entry (cell_entry[gi+1]),
          .keep        (cell_keep[gi]),
          .entry       (cell_entry[gi])
        );
      end
    end
  endgenerate

  // result of the current item
  always_comb begin
    res_value  = '0;
    res_status = ST_DONE;
    count_nxt  = count_r;
    unique case (in_tuser[0])
      OP_ENQ: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value = cell_entry[0].value;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, out_value_r};
  assign out_tuser  = out_status_r;

  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an accepted enqueue on a full store is reported as dropped
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser[0] == OP_ENQ && is_full) |=>
      (out_tvalid && out_tuser == ST_FULL && $stable(count_r)))
    else $error("enqueue on full not flagged");

  // a successful dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.deq |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue count mismatch");

  // an idle result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

FILE: hw/rtl/spq_cell.sv
// One storage cell of the sorted chain: holds one entry, trades with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,   // this slot lies below the entry count
  input  logic       left_keep,  // cell toward the head keeps its entry
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output logic       keep,
  output entry_t     entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // stays put on insert when it outranks or ties the new entry
  assign keep  = occupied && (entry_r.prio >= ctrl.new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.enq) begin
      if (!keep) begin
        entry_nxt = left_keep ? ctrl.new_entry : left_entry;
      end
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: test/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: directed table, then random push/pop traffic.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1926;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES  = 10;    // drain time once nothing is pending

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  // Directed stimulus row. When pinned is set, res is the expected result
  // as typed in; otherwise the expectation comes from the scoreboard queue.
  typedef struct packed {
    logic              op;
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
    logic              pinned;
    queue_result_t     res;
  } dir_row_t;

  localparam queue_result_t NO_PIN = '0;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [31:0] item_value, [47:32] item_priority
  logic [0:0]  in_tuser   = '0;   // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] out_value, [36:32] occupancy, rest zero
  logic [1:0]  out_tuser;         // [1:0] status

  // Pinned expectation travels with the item so the monitor samples it at
  // the same edge as the transfer.
  logic          row_pinned = 1'b0;
  queue_result_t row_expect = '0;

  always #6 clk = ~clk;

  sorted_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------
  // Shadow queue: a sorted copy of what the block should be holding.
  // Slot 0 is served next; ties keep arrival order.
  // ---------------------------------------------------------------------
  entry_t held [CAPACITY];
  int     held_count = 0;

  queue_result_t pending_results [$];
  int            errors = 0;

  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic [VAL_W-1:0] v,
                                                   input logic [PRIO_W-1:0] p);
    queue_result_t r;
    int pos;
    r.value  = '0;
    r.status = ST_DONE;
    if (op == OP_ENQ) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;                 // dropped, store untouched
      end else begin
        // insert behind every entry with priority >= ours (signed compare)
        pos = 0;
        while (pos < held_count && $signed(held[pos].prio) >= $signed(p)) pos++;
        for (int i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].value = v;
        held[pos].prio  = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;                // value stays zero
      end else begin
        r.value = held[0].value;
        for (int i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
      end
    end
    r.occ = held_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    $display("%0t ns ERROR %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. Input transfers are
  // handled first so a same-edge result could still find its expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready === 1'b1) begin
        want = apply_queue_op(in_tuser[0], in_tdata[31:0], in_tdata[47:32]);
        if (row_pinned) want = row_expect;
        pending_results.push_back(want);
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        if (pending_results.size() == 0) begin
          note_error($sformatf("result with nothing pending: value %h status %0d occ %0d",
                               out_tdata[31:0], out_tuser, out_tdata[36:32]));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[31:0] !== want.value)
            note_error($sformatf("out_value expected %h, actual %h",
                                 want.value, out_tdata[31:0]));
          if (out_tuser !== want.status)
            note_error($sformatf("status expected %0d, actual %0d",
                                 want.status, out_tuser));
          if (out_tdata[36:32] !== want.occ)
            note_error($sformatf("occupancy expected %0d, actual %0d",
                                 want.occ, out_tdata[36:32]));
        end
      end
    end
  end

  // Watchdog: a hang shows up as a long stretch with no transfer at all.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns timeout, %0d results still pending", $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side backpressure: steady stretches, short random stalls and
  // the occasional long stall.
  // ---------------------------------------------------------------------
  int rdy_hold = 0;
  always @(posedge clk) begin
    int r;
    if (rdy_hold > 0) begin
      rdy_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_tready <= 1'b1;
        rdy_hold = $urandom_range(20, 80);
      end else if (r < 15) begin
        out_tready <= 1'b0;
        rdy_hold = $urandom_range(8, 40);
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
        rdy_hold = $urandom_range(0, 3);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: optional gap, then hold the item until it is accepted.
  // ---------------------------------------------------------------------
  int send_steady_left = 0;

  task automatic drive_item(input logic op, input logic [VAL_W-1:0] v,
                            input logic [PRIO_W-1:0] p, input logic pinned,
                            input queue_result_t pin_res);
    int gap;
    int r;
    if (send_steady_left > 0) begin
      send_steady_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_steady_left = $urandom_range(20, 100);
        gap = 0;
      end else if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 30);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {p, v};
    in_tuser   <= op;
    row_pinned <= pinned;
    row_expect <= pin_res;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
  endtask

  // Directed table: empty pop, extremes of value and priority, three-way
  // ties, fill to capacity, push on full, then pops in priority order.
  dir_row_t dir_rows [24] = '{
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{OP_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, '{32'h0, ST_DONE, 5'd1}},
    '{OP_ENQ, 32'h8000_0000, 16'h8000, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h1111_1111, 16'h0005, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h2222_2222, 16'h0005, 1'b0, NO_PIN},
    '{OP_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h3333_3333, 16'h0005, 1'b0, NO_PIN},
    '{OP_ENQ, 32'hAAAA_AAAA, 16'h7FFF, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h5555_5555, 16'h8000, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0001, 16'h0001, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0002, 16'h4000, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0003, 16'hC000, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0004, 16'h5555, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0005, 16'hAAAA, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0006, 16'h7FFE, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h0000_0007, 16'h8001, 1'b0, NO_PIN},
    '{OP_ENQ, 32'h1234_5678, 16'h7FFF, 1'b1, '{32'h0, ST_FULL, 5'd16}},
    '{OP_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{32'h7FFF_FFFF, ST_DONE, 5'd15}},
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN},
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN},
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN},
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN},
    '{OP_DEQ, 32'h0000_0000, 16'h0000, 1'b0, NO_PIN}
  };

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int   mode_left;
    int   push_pct;
    int   r;
    logic op;
    logic [PRIO_W-1:0] p;
    mode_left = 0;
    push_pct  = 50;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k])
      drive_item(dir_rows[k].op, dir_rows[k].value, dir_rows[k].prio,
                 dir_rows[k].pinned, dir_rows[k].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // now and then hold off until the block has drained every result;
      // one edge first so the monitor has logged the last transfer
      if (n % 480 == 240) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      // fill-heavy, drain-heavy and balanced phases push the store
      // against both full and empty many times
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      mode_left--;
      op = ($urandom_range(0, 99) < push_pct) ? OP_ENQ : OP_DEQ;
      // many ties from a narrow band, some extremes, the rest anywhere
      r = $urandom_range(0, 99);
      if (r < 40) p = 16'($urandom_range(0, 6)) - 16'd3;
      else if (r < 50) begin
        case ($urandom_range(0, 3))
          0: p = 16'h7FFF;
          1: p = 16'h8000;
          2: p = 16'h0000;
          default: p = 16'hFFFF;
        endcase
      end else p = 16'($urandom);
      drive_item(op, $urandom, p, 1'b0, NO_PIN);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
